[sv/stb_pkg.sv]
// Package for the software timer bank: sizes, request codes and controller states.
package stb_pkg;

	localparam int TIMERS    = 8;
	localparam int IDX_W     = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int REQ_W     = 3;
	localparam int ID_W      = 3;
	localparam int CNT_W     = 32;
	localparam int TIME_W    = 31;
	localparam int DIG_W     = 4;
	localparam int DIGITS    = CNT_W / DIG_W;
	localparam int DIG_CNT_W = $clog2(DIGITS);
	localparam int GRP_W     = 4;

	localparam logic [GRP_W-1:0]  GROUP_LEN = GRP_W'(10);
	localparam logic [TIME_W-1:0] RUN_WRAP  = {TIME_W{1'b1}};

	localparam logic [REQ_W-1:0] REQ_TICK       = 3'd0;
	localparam logic [REQ_W-1:0] REQ_START_ONCE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_START_AUTO = 3'd2;
	localparam logic [REQ_W-1:0] REQ_STOP       = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CHECK      = 3'd4;
	localparam logic [REQ_W-1:0] REQ_READ       = 3'd5;
	localparam logic [REQ_W-1:0] REQ_ELAPSED    = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRD,
		ST_TLOAD,
		ST_TDEC,
		ST_TWB,
		ST_RADD,
		ST_RFIN,
		ST_E1,
		ST_E2LD,
		ST_E2,
		ST_EFIN
	} state_t;

endpackage

[sv/soft_timer_bank.sv]
// Software timer bank: countdown timers, run-time counter and elapsed-time unit.
//
// One word is taken when start is high and busy is low; every word gives exactly one
// result, shown on hit, time_value and ten_tick_mark for the single cycle in which done
// is high, and the receiver cannot stall it. Start, stop, check, read and unused codes
// give their result in the cycle after the word is taken. An elapsed request makes a
// pass through the 4-bit serial adder, a load step, another pass through the adder and
// a finish step. A tick sweeps the timers in turn: each timer is read from the count
// memory, decremented one nibble per cycle through the same serial adder and, if it
// was running, written back; the run-time counter is then incremented through the
// adder, followed by a finish step. busy stays high throughout, and the result of a
// tick or an elapsed request appears in the first cycle after busy falls.
module soft_timer_bank (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [stb_pkg::REQ_W-1:0]   req_type,
	input  logic [stb_pkg::ID_W-1:0]    timer_id,
	input  logic [stb_pkg::CNT_W-1:0]   period,
	input  logic                        clear_on_hit,
	input  logic [stb_pkg::TIME_W-1:0]  last_time,
	output logic                        done,
	output logic                        hit,
	output logic [stb_pkg::TIME_W-1:0]  time_value,
	output logic                        ten_tick_mark
);
	import stb_pkg::*;

	state_t state_q, state_d;

	logic [DIG_CNT_W-1:0] dig_q;
	logic [IDX_W-1:0]     idx_q;
	logic [TIME_W-1:0]    run_q;
	logic [GRP_W-1:0]     grp_q;
	logic [TIMERS-1:0]    expired_q;
	logic [TIMERS-1:0]    auto_q;
	logic [TIMERS-1:0]    rem_vld_q;
	logic [TIMERS-1:0]    rel_vld_q;
	logic                 done_q;
	logic                 hit_q;
	logic [TIME_W-1:0]    tv_q;
	logic                 mark_q;

	// Serial adder datapath.
	logic [CNT_W-1:0] a_q;
	logic [CNT_W-1:0] b_q;
	logic             cy_q;
	logic             nz_q;
	logic [DIG_W:0]   dsum;

	// Count and reload memories.
	logic [CNT_W-1:0] rem_mem [TIMERS];
	logic [CNT_W-1:0] rel_mem [TIMERS];
	logic [CNT_W-1:0] rem_rd_q;
	logic [CNT_W-1:0] rel_rd_q;
	logic             rem_rv_q;
	logic             rel_rv_q;
	logic [CNT_W-1:0] rem_eff;
	logic [CNT_W-1:0] rel_eff;

	logic             rem_we;
	logic [IDX_W-1:0] rem_wa;
	logic [CNT_W-1:0] rem_wd;
	logic             rel_we;

	logic             accept;
	logic             id_ok;
	logic [IDX_W-1:0] id_idx;
	logic             dig_last;
	logic             idx_last;
	logic             is_start;
	logic             hit_zero;
	logic [TIME_W-1:0] run_new;
	logic [GRP_W-1:0]  grp_inc;

	assign accept   = start && (state_q == ST_IDLE);
	assign id_ok    = 32'(timer_id) < 32'(TIMERS);
	assign id_idx   = IDX_W'(timer_id);
	assign dig_last = dig_q == DIG_CNT_W'(DIGITS - 1);
	assign idx_last = idx_q == IDX_W'(TIMERS - 1);
	assign is_start = (req_type == REQ_START_ONCE) || (req_type == REQ_START_AUTO);
	assign hit_zero = a_q == '0;
	assign rem_eff  = rem_rv_q ? rem_rd_q : '0;
	assign rel_eff  = rel_rv_q ? rel_rd_q : '0;
	assign dsum     = {1'b0, a_q[DIG_W-1:0]} + {1'b0, b_q[DIG_W-1:0]} + {{DIG_W{1'b0}}, cy_q};
	assign run_new  = (a_q[TIME_W-1:0] == RUN_WRAP) ? '0 : a_q[TIME_W-1:0];
	assign grp_inc  = grp_q + GRP_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rem_we  = 1'b0;
		rem_wa  = idx_q;
		rem_wd  = '0;
		rel_we  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_TICK) begin
						state_d = ST_TRD;
					end else if (req_type == REQ_ELAPSED) begin
						state_d = ST_E1;
					end
					if (id_ok && is_start) begin
						rem_we = 1'b1;
						rem_wa = id_idx;
						rem_wd = period;
						rel_we = 1'b1;
					end else if (id_ok && (req_type == REQ_STOP)) begin
						rem_we = 1'b1;
						rem_wa = id_idx;
					end
				end
			end
			ST_TRD:   state_d = ST_TLOAD;
			ST_TLOAD: state_d = ST_TDEC;
			ST_TDEC: begin
				if (dig_last) begin
					state_d = ST_TWB;
				end
			end
			ST_TWB: begin
				// An idle timer is left untouched; one that reaches zero may reload.
				rem_we  = nz_q;
				rem_wd  = (hit_zero && auto_q[idx_q]) ? rel_eff : a_q;
				state_d = idx_last ? ST_RADD : ST_TRD;
			end
			ST_RADD: begin
				if (dig_last) begin
					state_d = ST_RFIN;
				end
			end
			ST_RFIN: state_d = ST_IDLE;
			ST_E1: begin
				if (dig_last) begin
					state_d = ST_E2LD;
				end
			end
			ST_E2LD: state_d = ST_E2;
			ST_E2: begin
				if (dig_last) begin
					state_d = ST_EFIN;
				end
			end
			ST_EFIN: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state, flags and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_q     <= '0;
			idx_q     <= '0;
			run_q     <= '0;
			grp_q     <= '0;
			expired_q <= '0;
			auto_q    <= '0;
			rem_vld_q <= '0;
			rel_vld_q <= '0;
			done_q    <= 1'b0;
			hit_q     <= 1'b0;
			tv_q      <= '0;
			mark_q    <= 1'b0;
		end else begin
			if (rem_we) begin
				rem_vld_q[rem_wa] <= 1'b1;
			end
			if (rel_we) begin
				rel_vld_q[id_idx] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					done_q <= accept && (req_type != REQ_TICK)
						&& (req_type != REQ_ELAPSED);
					if (accept) begin
						hit_q  <= id_ok && (req_type == REQ_CHECK) && expired_q[id_idx];
						tv_q   <= (req_type == REQ_READ) ? run_q : '0;
						mark_q <= 1'b0;
						idx_q  <= '0;
						dig_q  <= '0;
						if (id_ok && is_start) begin
							expired_q[id_idx] <= 1'b0;
							auto_q[id_idx]    <= req_type == REQ_START_AUTO;
						end
						if (id_ok && (req_type == REQ_STOP)) begin
							expired_q[id_idx] <= 1'b0;
							auto_q[id_idx]    <= 1'b0;
						end
						if (id_ok && (req_type == REQ_CHECK) && expired_q[id_idx]
								&& clear_on_hit) begin
							expired_q[id_idx] <= 1'b0;
						end
					end
				end
				ST_TDEC, ST_RADD, ST_E1, ST_E2: begin
					done_q <= 1'b0;
					dig_q  <= dig_last ? '0 : dig_q + DIG_CNT_W'(1);
				end
				ST_TWB: begin
					done_q <= 1'b0;
					if (nz_q && hit_zero) begin
						expired_q[idx_q] <= 1'b1;
					end
					if (!idx_last) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_RFIN: begin
					run_q  <= run_new;
					tv_q   <= run_new;
					done_q <= 1'b1;
					if (grp_inc >= GROUP_LEN) begin
						grp_q  <= '0;
						mark_q <= 1'b1;
					end else begin
						grp_q <= grp_inc;
					end
				end
				ST_EFIN: begin
					tv_q   <= a_q[TIME_W-1:0];
					done_q <= 1'b1;
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	// Serial adder: one nibble a cycle, result shifted in from the top.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && (req_type == REQ_ELAPSED)) begin
					// Run time minus last time, as an add of the complement.
					a_q  <= {1'b0, run_q};
					b_q  <= ~{1'b0, last_time};
					cy_q <= 1'b1;
				end
			end
			ST_TLOAD: begin
				a_q  <= rem_eff;
				b_q  <= '1;
				cy_q <= 1'b0;
				nz_q <= rem_eff != '0;
			end
			ST_TDEC, ST_RADD, ST_E1, ST_E2: begin
				a_q  <= {dsum[DIG_W-1:0], a_q[CNT_W-1:DIG_W]};
				b_q  <= {{DIG_W{1'b0}}, b_q[CNT_W-1:DIG_W]};
				cy_q <= dsum[DIG_W];
			end
			ST_TWB: begin
				a_q  <= {1'b0, run_q};
				b_q  <= '0;
				cy_q <= 1'b1;
			end
			ST_E2LD: begin
				// A borrow means the run time has wrapped: take one more off.
				b_q  <= cy_q ? '0 : '1;
				cy_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rem_we) begin
			rem_mem[rem_wa] <= rem_wd;
		end
		if (rel_we) begin
			rel_mem[id_idx] <= period;
		end
		if (state_q == ST_TRD) begin
			rem_rd_q <= rem_mem[idx_q];
			rel_rd_q <= rel_mem[idx_q];
			rem_rv_q <= rem_vld_q[idx_q];
			rel_rv_q <= rel_vld_q[idx_q];
		end
	end

	assign busy          = state_q != ST_IDLE;
	assign done          = done_q;
	assign hit           = hit_q;
	assign time_value    = tv_q;
	assign ten_tick_mark = mark_q;

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an accepted word");

	a_group_range: assert property (@(posedge clk) disable iff (!arst_n)
		grp_q < GROUP_LEN)
		else $error("tick group counter out of range");

	a_run_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q != RUN_WRAP)
		else $error("run time reached the wrap value");

	a_sweep_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RADD) && (dig_q == '0) |-> idx_last)
		else $error("run-time update began before the timer sweep ended");

	a_mark_alone: assert property (@(posedge clk) disable iff (!arst_n)
		done && ten_tick_mark |-> !hit)
		else $error("tick marker outside a tick result");

endmodule
